@@ rtl/wtsc_pkg.sv @@
package wtsc_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam int KEY_CHARS_DEF = 8;

  localparam int KEY_W  = 64;
  localparam int LEN_W  = 8;
  localparam int LINE_W = 16;
  localparam int CNT_W  = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic              has_word;
    logic              eot;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
  } tok_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
  } entry_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NL) || (c == CH_SP) || (c == CH_DOT) ||
           (c == CH_COMMA) || (c == CH_COLON);
  endfunction

endpackage

@@ rtl/wtsc_front.sv @@
module wtsc_front
  import wtsc_pkg::*;
#(
  parameter int KeyChars = KEY_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       q_push,
  output tok_t       q_tok
);

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              zero_r, zero_nxt;
  logic              acc;
  logic              delim;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign delim    = is_delim(in_text_byte);

  always_comb begin
    key_nxt  = key_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    zero_nxt = zero_r;
    q_tok    = '0;
    if (delim) begin
      q_tok.has_word = (len_r != '0);
      q_tok.key      = key_r;
      q_tok.len      = len_r;
      q_tok.line     = line_r;
      key_nxt        = '0;
      len_nxt        = '0;
      zero_nxt       = 1'b0;
      if (in_text_byte == CH_NL && line_r != '1) begin
        line_nxt = line_r + 1'b1;
      end
    end else begin
      if (len_r < LEN_W'(KeyChars) && !zero_r) begin
        for (int k = 0; k < 8; k++) begin
          if (len_r == LEN_W'(k)) begin
            key_nxt[KEY_W-1-8*k -: 8] = in_text_byte;
          end
        end
        if (in_text_byte == 8'h00) begin
          zero_nxt = 1'b1;
        end
      end
      if (len_r != '1) begin
        len_nxt = len_r + 1'b1;
      end
    end
    if (in_end_of_text) begin
      q_tok.eot = 1'b1;
      if (!delim) begin
        q_tok.has_word = 1'b1;
        q_tok.key      = key_nxt;
        q_tok.len      = len_nxt;
        q_tok.line     = line_r;
      end
      key_nxt  = '0;
      len_nxt  = '0;
      zero_nxt = 1'b0;
      line_nxt = LINE_W'(1);
    end
    q_push = acc && (q_tok.has_word || q_tok.eot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      len_r  <= '0;
      line_r <= LINE_W'(1);
      zero_r <= 1'b0;
    end else if (acc) begin
      key_r  <= key_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
      zero_r <= zero_nxt;
    end
  end

endmodule

@@ rtl/wtsc_fifo.sv @@
module wtsc_fifo
  import wtsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output tok_t head_tok
);

  tok_t               buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r;
  logic [FIFO_AW-1:0] rd_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full      = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_tok  = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/wtsc_back.sv @@
module wtsc_back
  import wtsc_pkg::*;
#(
  parameter int MaxWords = MAX_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  tok_t              tok,
  output logic              tok_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KEY_W-1:0]  out_word_key,
  output logic [LEN_W-1:0]  out_word_length,
  output logic [LINE_W-1:0] out_line_number,
  output logic [CNT_W-1:0]  out_repeat_count,
  output logic              out_last_result,
  output logic              out_words_dropped
);

  localparam int AW = $clog2(MaxWords);

  typedef enum logic [1:0] {S_STORE, S_SCAN, S_COUNT, S_EMIT} state_t;

  state_t             st_r;
  entry_t             mem [MaxWords];
  entry_t             rd_q;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [CNT_W-1:0]   n_r, n_aft;
  logic               ovf_r, ovf_aft;
  logic [CNT_W-1:0]   iss_r;
  logic               dv_r;
  logic [AW-1:0]      didx_r;
  logic               first_r;
  logic               found_r;
  logic [KEY_W-1:0]   best_key_r, prev_key_r;
  logic [AW-1:0]      best_idx_r, prev_idx_r;
  logic [LEN_W-1:0]   best_len_r;
  logic [LINE_W-1:0]  best_line_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   emitted_r;
  logic               last_r;
  logic               out_valid_r;
  logic               better;
  logic               iss_done;

  assign tok_pop = (st_r == S_STORE) && tok_valid;
  assign wr_en   = tok_pop && tok.has_word && (n_r < CNT_W'(MaxWords));
  assign n_aft   = wr_en ? n_r + 1'b1 : n_r;
  assign ovf_aft = ovf_r || (tok.has_word && !wr_en);
  assign rd_addr = iss_r[AW-1:0];
  assign iss_done = (iss_r == n_r);

  assign better = (first_r || {rd_q.key, didx_r} > {prev_key_r, prev_idx_r}) &&
                  (!found_r || {rd_q.key, didx_r} < {best_key_r, best_idx_r});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[n_r[AW-1:0]] <= '{key: tok.key, len: tok.len, line: tok.line};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_STORE;
      n_r         <= '0;
      ovf_r       <= 1'b0;
      iss_r       <= '0;
      dv_r        <= 1'b0;
      first_r     <= 1'b1;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (st_r)
        S_STORE: begin
          if (tok_pop) begin
            if (tok.eot && n_aft == '0) begin
              n_r   <= '0;
              ovf_r <= 1'b0;
            end else begin
              n_r   <= n_aft;
              ovf_r <= ovf_aft;
              if (tok.eot) begin
                st_r      <= S_SCAN;
                first_r   <= 1'b1;
                found_r   <= 1'b0;
                iss_r     <= '0;
                dv_r      <= 1'b0;
                emitted_r <= '0;
              end
            end
          end
        end
        S_SCAN: begin
          if (!iss_done) begin
            iss_r <= iss_r + 1'b1;
          end
          dv_r   <= !iss_done;
          didx_r <= iss_r[AW-1:0];
          if (dv_r && better) begin
            best_key_r  <= rd_q.key;
            best_idx_r  <= didx_r;
            best_len_r  <= rd_q.len;
            best_line_r <= rd_q.line;
            found_r     <= 1'b1;
          end
          if (iss_done && !dv_r) begin
            st_r  <= S_COUNT;
            iss_r <= '0;
            cnt_r <= '0;
          end
        end
        S_COUNT: begin
          if (!iss_done) begin
            iss_r <= iss_r + 1'b1;
          end
          dv_r <= !iss_done;
          if (dv_r && rd_q.key == best_key_r) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (iss_done && !dv_r) begin
            st_r        <= S_EMIT;
            last_r      <= (emitted_r + 1'b1 == n_r);
            out_valid_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            emitted_r   <= emitted_r + 1'b1;
            if (last_r) begin
              st_r  <= S_STORE;
              n_r   <= '0;
              ovf_r <= 1'b0;
            end else begin
              prev_key_r <= best_key_r;
              prev_idx_r <= best_idx_r;
              first_r    <= 1'b0;
              found_r    <= 1'b0;
              iss_r      <= '0;
              st_r       <= S_SCAN;
            end
          end
        end
        default: begin
          st_r <= S_STORE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word_key      = best_key_r;
  assign out_word_length   = best_len_r;
  assign out_line_number   = best_line_r;
  assign out_repeat_count  = cnt_r;
  assign out_last_result   = last_r;
  assign out_words_dropped = ovf_r;

endmodule

@@ rtl/word_tokenize_sort_count.sv @@
// Word frequency sort over a byte stream. Bytes are taken one per cycle when
// input does not stall and split into words; finished words wait in a 4-entry
// queue and are written to a stored-word memory of MaxWords entries. After the
// end-of-text byte the block emits every stored word, ordered by key and then
// by arrival (and so by line), with the total count of its key. Each result
// takes two passes over the single read port of that memory (one to find the
// next word, one to count its key). Input stalls only while that queue is full.
module word_tokenize_sort_count
  import wtsc_pkg::*;
#(
  parameter int MaxWords = MAX_WORDS_DEF,
  parameter int KeyChars = KEY_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KEY_W-1:0]  out_word_key,
  output logic [LEN_W-1:0]  out_word_length,
  output logic [LINE_W-1:0] out_line_number,
  output logic [CNT_W-1:0]  out_repeat_count,
  output logic              out_last_result,
  output logic              out_words_dropped
);

  logic q_full;
  logic q_push;
  tok_t q_tok;
  logic q_pop;
  logic q_not_empty;
  tok_t q_head;

  wtsc_front #(.KeyChars(KeyChars)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_tok          (q_tok)
  );

  wtsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (q_head)
  );

  wtsc_back #(.MaxWords(MaxWords)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (q_not_empty),
    .tok               (q_head),
    .tok_pop           (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word_key      (out_word_key),
    .out_word_length   (out_word_length),
    .out_line_number   (out_line_number),
    .out_repeat_count  (out_repeat_count),
    .out_last_result   (out_last_result),
    .out_words_dropped (out_words_dropped)
  );

endmodule

@@ dv/tb_word_tokenize_sort_count.sv @@
`timescale 1ns / 100ps

module tb_word_tokenize_sort_count;
  import wtsc_pkg::*;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic [CNT_W-1:0]  cnt;
    logic              last;
    logic              dropped;
  } occurrence_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_text_byte;
  logic              in_end_of_text;
  logic              out_valid;
  logic              out_stall;
  logic [KEY_W-1:0]  out_word_key;
  logic [LEN_W-1:0]  out_word_length;
  logic [LINE_W-1:0] out_line_number;
  logic [CNT_W-1:0]  out_repeat_count;
  logic              out_last_result;
  logic              out_words_dropped;

  word_tokenize_sort_count dut (.*);

  occurrence_t sorted_words_q[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  int          sent_count;

  logic [KEY_W-1:0]  word_keys[MAX_WORDS_DEF];
  logic [LEN_W-1:0]  word_lens[MAX_WORDS_DEF];
  logic [LINE_W-1:0] word_lines[MAX_WORDS_DEF];
  int                word_total;
  logic [KEY_W-1:0]  open_key;
  logic [LEN_W-1:0]  open_len;
  logic [LINE_W-1:0] line_now;
  logic              dropped_seen;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #50ms;
    $display("word_tokenize_sort_count verification failed");
    $finish;
  end

  function automatic bit is_sep(logic [7:0] c);
    return c inside {CH_NL, CH_SP, CH_DOT, CH_COMMA, CH_COLON};
  endfunction

  function automatic void clear_text();
    word_total   = 0;
    open_key     = '0;
    open_len     = '0;
    line_now     = LINE_W'(1);
    dropped_seen = 1'b0;
  endfunction

  function automatic void close_word();
    if (open_len != 0) begin
      if (word_total < MAX_WORDS_DEF) begin
        word_keys[word_total]  = open_key;
        word_lens[word_total]  = open_len;
        word_lines[word_total] = line_now;
        word_total++;
      end else begin
        dropped_seen = 1'b1;
      end
    end
    open_key = '0;
    open_len = '0;
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic eot);
    int ord[MAX_WORDS_DEF];
    int j;
    int cur;
    int cnt;
    occurrence_t o;
    if (is_sep(c)) begin
      close_word();
      if (c == CH_NL && line_now != 16'hFFFF) line_now++;
    end else begin
      if (open_len < KEY_CHARS_DEF) begin
        if (open_len == 0 || open_key[8*(8-open_len) +: 8] != 8'h00)
          open_key[8*(7-open_len) +: 8] = c;
      end
      if (open_len != 8'hFF) open_len++;
    end
    if (!eot) return;
    close_word();
    for (int i = 0; i < word_total; i++) begin
      cur = i;
      j = i;
      while (j > 0 && (word_keys[ord[j-1]] > word_keys[cur] ||
             (word_keys[ord[j-1]] == word_keys[cur] &&
              word_lines[ord[j-1]] > word_lines[cur]))) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    for (int i = 0; i < word_total; i++) begin
      cnt = 0;
      for (int k = 0; k < word_total; k++)
        if (word_keys[k] == word_keys[ord[i]]) cnt++;
      o.key     = word_keys[ord[i]];
      o.len     = word_lens[ord[i]];
      o.line    = word_lines[ord[i]];
      o.cnt     = CNT_W'(cnt);
      o.last    = (i == word_total - 1);
      o.dropped = dropped_seen;
      sorted_words_q.push_back(o);
    end
    clear_text();
  endfunction

  task automatic send_byte(logic [7:0] c, logic eot);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_text_byte   = c;
    in_end_of_text = eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(c, eot);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (sorted_words_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'(8'h61 + $urandom_range(3));
    if (r < 85) return 8'($urandom_range(255));
    return 8'h00;
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(4))
      0: return CH_NL;
      1: return CH_SP;
      2: return CH_DOT;
      3: return CH_COMMA;
      default: return CH_COLON;
    endcase
  endfunction

  task automatic send_random_text();
    int nwords;
    int wlen;
    logic [7:0] c;
    nwords = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    for (int w = 0; w < nwords; w++) begin
      wlen = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
      for (int i = 0; i < wlen; i++) begin
        c = rand_char();
        if (is_sep(c)) c = 8'h61;
        send_byte(c, 1'b0);
      end
      repeat ($urandom_range(1, 2)) send_byte(rand_sep(), 1'b0);
    end
    send_byte(($urandom_range(1) != 0) ? rand_sep() : 8'h62, 1'b1);
  endtask

  task automatic test_directed();
    send_text(" abc:abc\nab.,", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_text(" x", 1'b1);
    wait_drain();
    send_byte(CH_SP, 1'b1);
    wait_drain();
    send_text("abcdefghij abcdefghxy\nq", 1'b1);
    wait_drain();
  endtask

  task automatic test_random(int items);
    int start;
    start = sent_count;
    while (sent_count - start < items) begin
      send_random_text();
    end
    wait_drain();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < MAX_WORDS_DEF; i++) begin
      send_byte(8'(8'h61 + (i % 26)), 1'b0);
      send_byte(CH_SP, 1'b0);
    end
    send_byte(8'h6D, 1'b1);
    wait_drain();
  endtask

  task automatic test_long_word();
    repeat (255) send_byte(8'h7A, 1'b0);
    send_byte(8'h7A, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int i = 0; i < 8; i++) send_text("ba ", 1'b0);
    send_byte(8'h61, 1'b1);
    send_text("cc dd ee ff gg hh", 1'b1);
    wait_drain();
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else begin
        out_stall = (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    occurrence_t o;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_words_q.size() == 0) begin
        $error("unexpected word key=%h", out_word_key);
        fail_count++;
      end else begin
        o = sorted_words_q.pop_front();
        if (out_word_key !== o.key) begin
          $error("word_key exp %h got %h", o.key, out_word_key); fail_count++;
        end
        if (out_word_length !== o.len) begin
          $error("word_length exp %0d got %0d", o.len, out_word_length); fail_count++;
        end
        if (out_line_number !== o.line) begin
          $error("line_number exp %0d got %0d", o.line, out_line_number); fail_count++;
        end
        if (out_repeat_count !== o.cnt) begin
          $error("repeat_count exp %0d got %0d", o.cnt, out_repeat_count); fail_count++;
        end
        if (out_last_result !== o.last) begin
          $error("last_result exp %0d got %0d", o.last, out_last_result); fail_count++;
        end
        if (out_words_dropped !== o.dropped) begin
          $error("words_dropped exp %0d got %0d", o.dropped, out_words_dropped);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count     = 0;
    hold_cycles    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    sent_count     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = '0;
    in_end_of_text = 1'b0;
    clear_text();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 75;
    test_random(20);
    test_overflow();
    send_idle_pct = 75;
    recv_idle_pct = 20;
    test_random(20);
    test_long_word();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(20);
    test_backpressure();
    wait_drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && sorted_words_q.size() == 0) begin
      $display("word_tokenize_sort_count verification clean");
    end else begin
      $display("word_tokenize_sort_count verification failed");
    end
    $finish;
  end

endmodule
